// File: hw/rtl/apts_pkg.sv
package apts_pkg;

    localparam int MaxTasks  = 16;
    localparam int SlotBits  = 4;
    localparam int CountBits = 5;
    localparam int ClockBits = 32;
    localparam int PrioBits  = 6;

    typedef logic [SlotBits-1:0]  slot_t;
    typedef logic [CountBits-1:0] count_t;
    typedef logic [ClockBits-1:0] clock_t;
    typedef logic signed [PrioBits-1:0] prio_t;

    localparam prio_t PrioBest  = -6'sd20;
    localparam prio_t PrioWorst = 6'sd20;

    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_ADD    = 3'd1,
        FUNC_SETPRI = 3'd2,
        FUNC_REMOVE = 3'd3,
        FUNC_SLEEP  = 3'd4,
        FUNC_SCHED  = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAKE,
        ST_SCAN,
        ST_PICK,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic wake_step;
        logic scan_init;
        logic scan_step;
        logic pick;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sched;
        logic wake_done;
        logic scan_done;
    } stat_t;

    function automatic prio_t clamp_prio(logic [PrioBits-1:0] raw);
        prio_t v;
        begin
            v = prio_t'(raw);
            if (v < PrioBest) begin
                v = PrioBest;
            end else if (v > PrioWorst) begin
                v = PrioWorst;
            end
            return v;
        end
    endfunction

endpackage

// File: hw/rtl/aging_priority_task_scheduler.sv
// aging priority task scheduler
// s_axis request: one operation (tick, add, set priority, remove, sleep,
// schedule) per request; m_axis returns exactly one result per request.
// cfg channel writes quantum_ticks (reset 20); the user must write it only
// while the block is idle, which the block itself does not enforce.
// one request at a time: a non-schedule operation goes from EXEC to OUT;
// a schedule goes through WAKE, SCAN and PICK, whose wake and aging scan loops
// visit one entry per cycle, before OUT; with m_axis_tready held high the
// block goes from OUT, where the result is valid, to IDLE for the next request.
// the result is held in registers until m_axis_tready; no new request is
// accepted until the result has been taken.
// reset clears the task table, both lists, the clock and the quantum.
module aging_priority_task_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], task_slot[6:3], priority_req[12:7], sleep_ticks[28:13]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chosen_valid[0], chosen_slot[4:1], preempt[5], error[6], clock_now[38:7]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import apts_pkg::*;

    cmd_t   cmd;
    stat_t  stat;
    logic   cv, pre, err;
    slot_t  cs;
    clock_t cn;

    assign cfg_ready = 1'b1;

    apts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_taken(m_axis_tready),
        .stat(stat), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    apts_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .func(s_axis_tdata[2:0]), .task_slot(s_axis_tdata[6:3]),
        .priority_req(s_axis_tdata[12:7]), .sleep_ticks(s_axis_tdata[28:13]),
        .cfg_fire(cfg_valid && cfg_ready), .cfg_data(cfg_data),
        .chosen_valid(cv), .chosen_slot(cs), .preempt(pre), .error(err),
        .clock_now(cn)
    );

    assign m_axis_tdata = {1'b0, cn, err, pre, cs, cv};

endmodule

// File: hw/rtl/apts_ctrl.sv
module apts_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic           out_taken,
    input  apts_pkg::stat_t stat,
    output apts_pkg::cmd_t cmd,
    output logic           in_ready,
    output logic           out_valid
);
    import apts_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.is_sched) begin
                    state_next = ST_WAKE;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_WAKE: begin
                if (stat.wake_done) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    cmd.wake_step = 1'b1;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_PICK;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_PICK: begin
                cmd.pick   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_taken) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid)) else $error("ready and valid together");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_EXEC) else $error("load did not start");
    a_pick_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pick |=> out_valid) else $error("pick without result");
`endif

endmodule

// File: hw/rtl/apts_dpath.sv
module apts_dpath (
    input  logic            aclk,
    input  logic            aresetn,
    input  apts_pkg::cmd_t  cmd,
    output apts_pkg::stat_t stat,
    input  logic [2:0]      func,
    input  apts_pkg::slot_t task_slot,
    input  logic [5:0]      priority_req,
    input  logic [15:0]     sleep_ticks,
    input  logic            cfg_fire,
    input  logic [7:0]      cfg_data,
    output logic            chosen_valid,
    output apts_pkg::slot_t chosen_slot,
    output logic            preempt,
    output logic            error,
    output apts_pkg::clock_t clock_now
);
    import apts_pkg::*;

    slot_t  ready_reg [MaxTasks];
    slot_t  sleep_reg [MaxTasks];
    prio_t  sprio_reg [MaxTasks];
    prio_t  dprio_reg [MaxTasks];
    clock_t wake_reg  [MaxTasks];
    logic [MaxTasks-1:0] used_reg;
    count_t rcnt_reg, scnt_reg, idx_reg;
    clock_t clk_reg;
    logic [7:0] quant_reg, qticks_reg;
    slot_t  run_reg;
    logic [2:0]  func_reg;
    slot_t  slot_reg;
    logic [5:0]  prio_reg;
    logic [15:0] stk_reg;
    slot_t  best_reg;
    prio_t  bestp_reg;
    logic   val_reg, pre_reg, err_reg;

    // ready and sleep list membership of the addressed slot
    logic   in_ready, in_sleep;
    count_t rpos, spos;
    always_comb begin
        in_ready = 1'b0;
        in_sleep = 1'b0;
        rpos = '0;
        spos = '0;
        for (int i = 0; i < MaxTasks; i++) begin
            if (count_t'(i) < rcnt_reg && ready_reg[i] == slot_reg && !in_ready) begin
                in_ready = 1'b1;
                rpos = count_t'(i);
            end
            if (count_t'(i) < scnt_reg && sleep_reg[i] == slot_reg && !in_sleep) begin
                in_sleep = 1'b1;
                spos = count_t'(i);
            end
        end
    end

    slot_t  wslot, eslot;
    prio_t  ep;
    logic   wake_hit;
    assign wslot    = sleep_reg[idx_reg[SlotBits-1:0]];
    assign wake_hit = wake_reg[wslot] <= clk_reg;
    assign eslot    = ready_reg[idx_reg[SlotBits-1:0]];
    assign ep       = dprio_reg[eslot];

    assign stat.is_sched  = func_reg == FUNC_SCHED;
    assign stat.wake_done = idx_reg >= scnt_reg;
    assign stat.scan_done = idx_reg >= rcnt_reg;

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            rcnt_reg   <= '0;
            scnt_reg   <= '0;
            clk_reg    <= '0;
            quant_reg  <= '0;
            run_reg    <= '0;
            qticks_reg <= 8'd20;
            idx_reg    <= '0;
            val_reg    <= 1'b0;
            pre_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end else begin
            if (cfg_fire) begin
                qticks_reg <= cfg_data;
            end
            if (cmd.load) begin
                func_reg <= func;
                slot_reg <= task_slot;
                prio_reg <= priority_req;
                stk_reg  <= sleep_ticks;
                val_reg  <= 1'b0;
                pre_reg  <= 1'b0;
                err_reg  <= 1'b0;
                idx_reg  <= '0;
            end
            if (cmd.exec) begin
                case (func_reg)
                    FUNC_TICK: begin
                        clk_reg <= clk_reg + 1'b1;
                        if (quant_reg > 8'd1) begin
                            quant_reg <= quant_reg - 1'b1;
                        end else begin
                            quant_reg <= '0;
                            pre_reg   <= 1'b1;
                        end
                    end
                    FUNC_ADD: begin
                        if (used_reg[slot_reg]) begin
                            err_reg <= 1'b1;
                        end else begin
                            used_reg[slot_reg]  <= 1'b1;
                            sprio_reg[slot_reg] <= clamp_prio(prio_reg);
                            dprio_reg[slot_reg] <= clamp_prio(prio_reg);
                            if (rcnt_reg < count_t'(MaxTasks)) begin
                                ready_reg[rcnt_reg[SlotBits-1:0]] <= slot_reg;
                                rcnt_reg <= rcnt_reg + 1'b1;
                            end
                        end
                    end
                    FUNC_SETPRI: begin
                        if (!used_reg[slot_reg]) begin
                            err_reg <= 1'b1;
                        end else begin
                            sprio_reg[slot_reg] <= clamp_prio(prio_reg);
                            dprio_reg[slot_reg] <= clamp_prio(prio_reg);
                        end
                    end
                    FUNC_REMOVE: begin
                        if (!used_reg[slot_reg]) begin
                            err_reg <= 1'b1;
                        end else begin
                            used_reg[slot_reg] <= 1'b0;
                            if (in_ready) begin
                                for (int i = 0; i < MaxTasks - 1; i++) begin
                                    if (count_t'(i) >= rpos) begin
                                        ready_reg[i] <= ready_reg[i+1];
                                    end
                                end
                                rcnt_reg <= rcnt_reg - 1'b1;
                            end else if (in_sleep) begin
                                for (int i = 0; i < MaxTasks - 1; i++) begin
                                    if (count_t'(i) >= spos) begin
                                        sleep_reg[i] <= sleep_reg[i+1];
                                    end
                                end
                                scnt_reg <= scnt_reg - 1'b1;
                            end
                        end
                    end
                    FUNC_SLEEP: begin
                        if (!used_reg[slot_reg]) begin
                            err_reg <= 1'b1;
                        end else begin
                            wake_reg[slot_reg] <= clk_reg + clock_t'(stk_reg);
                            if (!in_sleep) begin
                                if (in_ready) begin
                                    for (int i = 0; i < MaxTasks - 1; i++) begin
                                        if (count_t'(i) >= rpos) begin
                                            ready_reg[i] <= ready_reg[i+1];
                                        end
                                    end
                                    rcnt_reg <= rcnt_reg - 1'b1;
                                end
                                if (scnt_reg < count_t'(MaxTasks)) begin
                                    sleep_reg[scnt_reg[SlotBits-1:0]] <= slot_reg;
                                    scnt_reg <= scnt_reg + 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // examine one sleeper per cycle, waking it if its wake time has come
            if (cmd.wake_step) begin
                if (wake_hit) begin
                    for (int i = 0; i < MaxTasks - 1; i++) begin
                        if (count_t'(i) >= idx_reg) begin
                            sleep_reg[i] <= sleep_reg[i+1];
                        end
                    end
                    scnt_reg <= scnt_reg - 1'b1;
                    if (rcnt_reg < count_t'(MaxTasks)) begin
                        ready_reg[rcnt_reg[SlotBits-1:0]] <= wslot;
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.scan_init) begin
                idx_reg   <= '0;
                best_reg  <= ready_reg[0];
                bestp_reg <= dprio_reg[ready_reg[0]];
            end
            // scan one ready entry per cycle, aging it
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (ep <= bestp_reg || best_reg == eslot) begin
                    best_reg  <= eslot;
                    bestp_reg <= (ep > PrioBest) ? prio_t'(ep - 6'sd1) : ep;
                end
                if (ep > PrioBest) begin
                    dprio_reg[eslot] <= ep - 6'sd1;
                end
            end
            if (cmd.pick && rcnt_reg != '0) begin
                dprio_reg[best_reg] <= sprio_reg[best_reg];
                quant_reg <= qticks_reg;
                run_reg   <= best_reg;
                val_reg   <= 1'b1;
            end
        end
    end

    assign chosen_valid = val_reg;
    assign chosen_slot  = val_reg ? best_reg : '0;
    assign preempt      = pre_reg;
    assign error        = err_reg;
    assign clock_now    = clk_reg;

`ifndef SYNTHESIS
    a_rcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= count_t'(MaxTasks)) else $error("ready count overflow");
    a_scnt: assert property (@(posedge aclk) disable iff (!aresetn)
        scnt_reg <= count_t'(MaxTasks)) else $error("sleep count overflow");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(val_reg && err_reg)) else $error("chosen with error");
`endif

endmodule
